// File: rtl/isg3_pkg.sv
// Shared types, sizes and index tables for the 3-D shape-gradient block.
// Used by isg3_ctrl, isg3_dp, isg3_div and the top level; depends on nothing.
package isg3_pkg;

  localparam int MAX_NODES   = 8;
  localparam int NODE_W      = $clog2(MAX_NODES + 1);
  localparam int NIDX_W      = $clog2(MAX_NODES);
  localparam int DIV_BITS    = 48;
  localparam int DIV_CNT_W   = $clog2(DIV_BITS);
  localparam int JAC_STEPS   = 9;
  localparam int COF_STEPS   = 18;
  localparam int DET_STEPS   = 3;
  localparam int OUT_STEPS   = 9;
  localparam int INV_ENTRIES = 9;

  typedef enum logic [1:0] {OP_JAC, OP_COF, OP_DET, OP_OUT} mul_op_t;

  typedef struct packed {
    logic              in_take;
    logic              store_en;
    logic              mul_en;
    mul_op_t           op;
    logic [4:0]        step;
    logic [NIDX_W-1:0] row;
    logic              sat_clear;
    logic              div_start;
    logic [3:0]        div_idx;
    logic              out_load;
    logic              singular;
    logic              last_result;
    logic [2:0]        node_index;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

  // Clamp a wide signed value to Q16.16 range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Row of a flat 3x3 index.
  function automatic logic [1:0] div3(input logic [3:0] s);
    logic [1:0] r;
    case (s)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      4'd6, 4'd7, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  // Column of a flat 3x3 index.
  function automatic logic [1:0] mod3(input logic [3:0] s);
    logic [1:0] r;
    case (s)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      4'd2, 4'd5, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] x, input logic [1:0] d);
    logic [2:0] t;
    t = {1'b0, x} + {1'b0, d};
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  function automatic logic [3:0] flat(input logic [1:0] r, input logic [1:0] k);
    return {r, 2'b00} - {2'b00, r} + {2'b00, k};
  endfunction

  // Transposed flat index.
  function automatic logic [3:0] tr9(input logic [3:0] s);
    return flat(mod3(s), div3(s));
  endfunction

  // Operands of the cofactor products: h selects the subtracted term.
  function automatic logic [3:0] cof_ia(input logic [3:0] e, input logic h);
    logic [1:0] r1, k1, k2;
    r1 = inc3(div3(e), 2'd1);
    k1 = inc3(mod3(e), 2'd1);
    k2 = inc3(mod3(e), 2'd2);
    return h ? flat(r1, k2) : flat(r1, k1);
  endfunction

  function automatic logic [3:0] cof_ib(input logic [3:0] e, input logic h);
    logic [1:0] r2, k1, k2;
    r2 = inc3(div3(e), 2'd2);
    k1 = inc3(mod3(e), 2'd1);
    k2 = inc3(mod3(e), 2'd2);
    return h ? flat(r2, k1) : flat(r2, k2);
  endfunction

endpackage

// File: rtl/isg3_div.sv
// Iterative signed divider, one quotient bit per cycle.
// Depends on isg3_pkg for the quotient width.
module isg3_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [63:0] quo
);

  logic                                busy;
  logic [isg3_pkg::DIV_CNT_W-1:0]      cnt;
  logic [isg3_pkg::DIV_BITS-1:0]       qsh;
  logic [isg3_pkg::DIV_BITS:0]         rem;
  logic [isg3_pkg::DIV_BITS:0]         dmag;
  logic                                neg;
  logic signed [63:0]                  num_abs;
  logic signed [63:0]                  den_abs;
  logic [isg3_pkg::DIV_BITS+1:0]       rs;
  logic [isg3_pkg::DIV_BITS+1:0]       diff;
  logic signed [63:0]                  qext;

  assign num_abs = num[63] ? -num : num;
  assign den_abs = den[63] ? -den : den;
  assign rs      = {rem, qsh[isg3_pkg::DIV_BITS-1]};
  assign diff    = rs - {1'b0, dmag};
  assign qext    = {{(64 - isg3_pkg::DIV_BITS){1'b0}}, qsh};
  assign quo     = neg ? -qext : qext;

  // Shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == isg3_pkg::DIV_CNT_W'(isg3_pkg::DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring step on the magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      qsh  <= num_abs[isg3_pkg::DIV_BITS-1:0];
      rem  <= '0;
      dmag <= den_abs[isg3_pkg::DIV_BITS:0];
      neg  <= num[63] ^ den[63];
    end else if (busy) begin
      if (!diff[isg3_pkg::DIV_BITS+1]) begin
        rem <= diff[isg3_pkg::DIV_BITS:0];
        qsh <= {qsh[isg3_pkg::DIV_BITS-2:0], 1'b1};
      end else begin
        rem <= rs[isg3_pkg::DIV_BITS:0];
        qsh <= {qsh[isg3_pkg::DIV_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/isg3_dp.sv
// Datapath: derivative store, Jacobian sums, cofactors, inverse, shared multiplier.
// Depends on isg3_pkg and isg3_div; driven by isg3_ctrl through dp_cmd_t.
module isg3_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  isg3_pkg::dp_cmd_t     cmd,
  output isg3_pkg::dp_stat_t    stat,
  input  logic signed [31:0]    dn_dr,
  input  logic signed [31:0]    dn_ds,
  input  logic signed [31:0]    dn_dt,
  input  logic signed [31:0]    coord_x,
  input  logic signed [31:0]    coord_y,
  input  logic signed [31:0]    coord_z,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [2:0]            node_index,
  output logic signed [31:0]    dn_dx,
  output logic signed [31:0]    dn_dy,
  output logic signed [31:0]    dn_dz,
  output logic                  singular,
  output logic                  last_result
);

  logic signed [31:0] din   [3];
  logic signed [31:0] xin   [3];
  logic signed [31:0] store [isg3_pkg::MAX_NODES][3];
  logic signed [63:0] jac   [9];
  logic signed [31:0] jmat  [9];
  logic signed [31:0] cof   [9];
  logic signed [31:0] inv   [9];
  logic signed [31:0] res   [3];
  logic signed [63:0] det;
  logic signed [63:0] accm;
  logic signed [63:0] prod_q;
  logic               mv_q;
  isg3_pkg::mul_op_t  op_q;
  logic [4:0]         step_q;
  logic [3:0]         div_idx_q;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [63:0] rnd;
  logic signed [63:0] m;
  logic [3:0]         s4;
  logic [3:0]         sq4;
  logic               div_done;
  logic signed [63:0] quo;
  logic signed [63:0] div_num;

  assign s4  = cmd.step[3:0];
  assign sq4 = step_q[3:0];

  // Select multiplier operands for the issued step
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.op)
      isg3_pkg::OP_JAC: begin
        opa = din[isg3_pkg::mod3(s4)];
        opb = xin[isg3_pkg::div3(s4)];
      end
      isg3_pkg::OP_COF: begin
        opa = jmat[isg3_pkg::cof_ia(cmd.step[4:1], cmd.step[0])];
        opb = jmat[isg3_pkg::cof_ib(cmd.step[4:1], cmd.step[0])];
      end
      isg3_pkg::OP_DET: begin
        opa = jmat[s4];
        opb = cof[s4];
      end
      isg3_pkg::OP_OUT: begin
        opa = store[cmd.row][isg3_pkg::mod3(s4)];
        opb = inv[isg3_pkg::tr9(s4)];
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Truncate the registered product toward zero
  assign rnd = prod_q + {48'd0, {16{prod_q[63]}}};
  assign m   = rnd >>> 16;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= opa * opb;
    op_q   <= cmd.op;
    step_q <= cmd.step;
  end

  // Latch the node and write its derivatives
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      din[0] <= dn_dr;
      din[1] <= dn_ds;
      din[2] <= dn_dt;
      xin[0] <= coord_x;
      xin[1] <= coord_y;
      xin[2] <= coord_z;
    end
    if (cmd.store_en) begin
      store[cmd.row][0] <= dn_dr;
      store[cmd.row][1] <= dn_ds;
      store[cmd.row][2] <= dn_dt;
    end
  end

  // Jacobian sums: accumulate, then saturate and clear when the element closes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < 9; e++) jac[e] <= '0;
    end else if (cmd.sat_clear) begin
      for (int e = 0; e < 9; e++) jac[e] <= '0;
    end else if (mv_q && op_q == isg3_pkg::OP_JAC) begin
      jac[sq4] <= jac[sq4] + m;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sat_clear) begin
      for (int e = 0; e < 9; e++) jmat[e] <= isg3_pkg::sat32(jac[e]);
    end
  end

  // Accumulate stage for cofactors, determinant and outputs
  always_ff @(posedge clk) begin
    if (mv_q) begin
      case (op_q)
        isg3_pkg::OP_COF: begin
          if (!step_q[0]) accm <= m;
          else cof[step_q[4:1]] <= isg3_pkg::sat32(accm - m);
        end
        isg3_pkg::OP_DET: begin
          det <= (step_q == 5'd0) ? m : det + m;
        end
        isg3_pkg::OP_OUT: begin
          if (isg3_pkg::mod3(sq4) == 2'd0) accm <= m;
          else accm <= accm + m;
          if (isg3_pkg::mod3(sq4) == 2'd2) begin
            res[isg3_pkg::div3(sq4)] <= isg3_pkg::sat32(accm + m);
          end
        end
        default: ;
      endcase
    end
  end

  // Inverse entries: cofactor transposed, scaled, over the determinant
  assign div_num = {{16{cof[isg3_pkg::tr9(cmd.div_idx)][31]}},
                    cof[isg3_pkg::tr9(cmd.div_idx)], 16'd0};

  isg3_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (det),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) div_idx_q <= cmd.div_idx;
    if (div_done) inv[div_idx_q] <= isg3_pkg::sat32(quo);
  end

  // Output register: load a beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      node_index  <= cmd.node_index;
      singular    <= cmd.singular;
      last_result <= cmd.last_result;
      dn_dx       <= cmd.singular ? 32'sd0 : res[0];
      dn_dy       <= cmd.singular ? 32'sd0 : res[1];
      dn_dz       <= cmd.singular ? 32'sd0 : res[2];
    end
  end

  assign stat.det_zero = (det == 64'sd0);
  assign stat.div_done = div_done;
  assign stat.out_busy = out_valid && out_stall;

endmodule

// File: rtl/isg3_ctrl.sv
// Controller: sequences node loading, inversion and per-node result emission.
// Depends on isg3_pkg; commands isg3_dp through dp_cmd_t.
module isg3_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                last_node,
  output logic                in_stall,
  input  isg3_pkg::dp_stat_t  stat,
  output isg3_pkg::dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SAT, S_COF, S_DET, S_CHECK,
    S_INV_START, S_INV_WAIT, S_OUT, S_EMIT
  } state_t;

  state_t                      state;
  logic [isg3_pkg::NODE_W-1:0] node_count;
  logic [isg3_pkg::NODE_W-1:0] p;
  logic [4:0]                  step;
  logic                        last_q;
  logic                        sing;
  logic                        has_room;
  logic                        is_last_out;

  assign has_room    = node_count < isg3_pkg::NODE_W'(isg3_pkg::MAX_NODES);
  assign is_last_out = (p == node_count - 1'b1);
  assign in_stall    = (state != S_IDLE);

  // Commands for the datapath
  always_comb begin
    cmd = '0;
    cmd.op = isg3_pkg::OP_JAC;
    cmd.step = step;
    cmd.row = p[isg3_pkg::NIDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        cmd.in_take  = in_valid;
        cmd.store_en = in_valid && has_room;
        cmd.row      = node_count[isg3_pkg::NIDX_W-1:0];
      end
      S_LOAD: begin
        cmd.mul_en = step < 5'(isg3_pkg::JAC_STEPS);
        cmd.op     = isg3_pkg::OP_JAC;
      end
      S_SAT: cmd.sat_clear = 1'b1;
      S_COF: begin
        cmd.mul_en = step < 5'(isg3_pkg::COF_STEPS);
        cmd.op     = isg3_pkg::OP_COF;
      end
      S_DET: begin
        cmd.mul_en = step < 5'(isg3_pkg::DET_STEPS);
        cmd.op     = isg3_pkg::OP_DET;
      end
      S_CHECK: ;
      S_INV_START: begin
        cmd.div_start = 1'b1;
        cmd.div_idx   = step[3:0];
      end
      S_INV_WAIT: ;
      S_OUT: begin
        cmd.mul_en = step < 5'(isg3_pkg::OUT_STEPS);
        cmd.op     = isg3_pkg::OP_OUT;
      end
      S_EMIT: begin
        cmd.out_load    = !stat.out_busy;
        cmd.singular    = sing;
        cmd.last_result = is_last_out;
        cmd.node_index  = p[2:0];
      end
      default: ;
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= '0;
      p          <= '0;
      step       <= '0;
      last_q     <= 1'b0;
      sing       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_q <= last_node;
            step   <= '0;
            if (has_room) begin
              node_count <= node_count + 1'b1;
              state      <= S_LOAD;
            end else if (last_node) begin
              state <= S_SAT;
            end
          end
        end
        S_LOAD: begin
          if (step == 5'(isg3_pkg::JAC_STEPS)) begin
            step  <= '0;
            state <= last_q ? S_SAT : S_IDLE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SAT: begin
          step  <= '0;
          state <= S_COF;
        end
        S_COF: begin
          if (step == 5'(isg3_pkg::COF_STEPS)) begin
            step  <= '0;
            state <= S_DET;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DET: begin
          if (step == 5'(isg3_pkg::DET_STEPS)) begin
            step  <= '0;
            state <= S_CHECK;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_CHECK: begin
          sing <= stat.det_zero;
          step <= '0;
          p    <= '0;
          state <= stat.det_zero ? S_OUT : S_INV_START;
        end
        S_INV_START: state <= S_INV_WAIT;
        S_INV_WAIT: begin
          if (stat.div_done) begin
            if (step == 5'(isg3_pkg::INV_ENTRIES - 1)) begin
              step  <= '0;
              state <= S_OUT;
            end else begin
              step  <= step + 1'b1;
              state <= S_INV_START;
            end
          end
        end
        S_OUT: begin
          if (step == 5'(isg3_pkg::OUT_STEPS)) begin
            step  <= '0;
            state <= S_EMIT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_EMIT: begin
          if (!stat.out_busy) begin
            if (is_last_out) begin
              node_count <= '0;
              p          <= '0;
              state      <= S_IDLE;
            end else begin
              p     <= p + 1'b1;
              state <= S_OUT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/isoparametric_shape_gradient_3d.sv
// 3-D isoparametric shape-function gradient in Q16.16. One node is taken per input beat
// and uses one shared 32x32 multiplier for nine Jacobian products. A node past the store
// depth is dropped. The node marked last closes the element: a saturate step, the
// cofactor products, the determinant products and a check, then nine divisions (one
// quotient bit per cycle) unless the determinant is zero. Each node's result then takes
// nine products and one output load, and results leave in load order through an
// output register. No new node is accepted until the last result of the element has
// been loaded.
module isoparametric_shape_gradient_3d (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] dn_dr,
  input  logic signed [31:0] dn_ds,
  input  logic signed [31:0] dn_dt,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic               last_node,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         node_index,
  output logic signed [31:0] dn_dx,
  output logic signed [31:0] dn_dy,
  output logic signed [31:0] dn_dz,
  output logic               singular,
  output logic               last_result
);

  isg3_pkg::dp_cmd_t  cmd;
  isg3_pkg::dp_stat_t stat;

  isg3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_node (last_node),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  isg3_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .dn_dr       (dn_dr),
    .dn_ds       (dn_ds),
    .dn_dt       (dn_dt),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .node_index  (node_index),
    .dn_dx       (dn_dx),
    .dn_dy       (dn_dy),
    .dn_dz       (dn_dz),
    .singular    (singular),
    .last_result (last_result)
  );

endmodule
